>>> rtl/rcsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcsd_pkg;

  localparam int TableBits  = 10;
  localparam int SampleBits = 24;
  localparam int TableSize  = 1 << TableBits;
  localparam int FracBits   = 16 - TableBits;
  localparam int PhaseBits  = 17;
  localparam int GainBits   = 16;
  localparam int StepBits   = 17;
  localparam int BalBits    = 17;
  localparam int MulAw      = (SampleBits > 17) ? SampleBits : 17;
  localparam int MulBw      = 32;
  localparam int ProdW      = MulAw + MulBw;

  localparam logic [PhaseBits-1:0] PhaseOne = PhaseBits'(65536);
  localparam logic [GainBits-1:0]  GainOne  = GainBits'(32768);

  localparam logic [1:0] ModeNormal  = 2'd0;
  localparam logic [1:0] ModeFadeOut = 2'd1;
  localparam logic [1:0] ModeFadeIn  = 2'd2;

  localparam logic [1:0] CfgFadeOutStep = 2'd0;
  localparam logic [1:0] CfgFadeInStep  = 2'd1;
  localparam logic [1:0] CfgOutputGain  = 2'd2;
  localparam logic [1:0] CfgBalance     = 2'd3;

  typedef logic [GainBits-1:0] rom_t [TableSize];

  function automatic logic [GainBits-1:0] cosine_entry(input int idx);
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] g;
    y  = 64'(idx) << (30 - TableBits);
    y2 = (y * y) >> 30;
    p  = 64'd85569278 - ((y2 * 64'd5026937) >> 30);
    p  = 64'd693598563 - ((y2 * p) >> 30);
    p  = 64'd1686629713 - ((y2 * p) >> 30);
    s  = (y * p) >> 30;
    g  = (s * s + (64'd1 << 44)) >> 45;
    if (g > 64'd32768) begin
      g = 64'd32768;
    end
    return g[GainBits-1:0];
  endfunction

  function automatic rom_t build_cosine_rom();
    rom_t rom;
    for (int k = 0; k < TableSize; k++) begin
      rom[k] = cosine_entry(k);
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

>>> rtl/raised_cosine_switch_duck.sv
// A beat steps through StMode, StRd0, StRd1, StInterp, StDuck, StGl, StGgl, StXl,
// StGr, StGgr, StXr, StDone, one beat at a time, with one shared multiplier and a
// single-port cosine ROM read twice per beat for interpolation.
// The next input beat is taken while a finished result waits in the output register.
// Reset (async, active low): idle, normal mode, phase at full gain,
// configuration at defaults; the ROM is constant and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module raised_cosine_switch_duck (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [rcsd_pkg::SampleBits-1:0] left_in_i,
  input  wire logic signed [rcsd_pkg::SampleBits-1:0] right_in_i,
  input  wire logic                                 change_request_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [rcsd_pkg::SampleBits-1:0]      left_out_o,
  output logic signed [rcsd_pkg::SampleBits-1:0]      right_out_o,
  output logic                                      swap_now_o,
  output logic                                      fading_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [1:0]                           cfg_index_i,
  input  wire logic [16:0]                          cfg_data_i
);

  localparam int S  = rcsd_pkg::SampleBits;
  localparam int PW = rcsd_pkg::ProdW;
  localparam int AW = rcsd_pkg::MulAw;
  localparam int BW = rcsd_pkg::MulBw;
  localparam int F  = rcsd_pkg::FracBits;
  localparam int TB = rcsd_pkg::TableBits;

  localparam rcsd_pkg::rom_t CosRom = rcsd_pkg::build_cosine_rom();

  localparam logic signed [PW-1:0] RoundHalf = $signed(PW'(1) << 28);
  localparam logic signed [PW-1:0] SatHi = $signed((PW'(1) << (S - 1)) - PW'(1));
  localparam logic signed [PW-1:0] SatLo = -SatHi - PW'(1);

  typedef enum logic [3:0] {
    StIdle, StMode, StRd0, StRd1, StInterp, StDuck, StGl, StGgl,
    StXl, StGr, StGgr, StXr, StDone
  } state_e;

  state_e state_q;

  logic [rcsd_pkg::StepBits-1:0] fade_out_step_q, fade_in_step_q;
  logic [rcsd_pkg::GainBits-1:0] output_gain_q;
  logic signed [rcsd_pkg::BalBits-1:0] balance_q;

  logic [1:0]                     mode_q;
  logic [rcsd_pkg::PhaseBits-1:0] phase_q;
  logic                           swap_q, fading_q, req_q, last_q;
  logic signed [S-1:0]            x_l_q, x_r_q, left_q;
  logic [TB-1:0]                  rom_addr_q;
  logic [rcsd_pkg::GainBits-1:0]  rom_q, t0_q, sg_q;
  logic signed [PW-1:0]           prod_q;

  logic                           out_valid_q;
  logic signed [S-1:0]            left_out_q, right_out_q;
  logic                           swap_out_q, fading_out_q;

  logic [1:0]                     mode_n;
  logic [rcsd_pkg::PhaseBits-1:0] phase_n;
  logic [rcsd_pkg::PhaseBits:0]   phase_sum;
  logic                           swap_n, fading_n;

  logic [rcsd_pkg::GainBits-1:0]  gl, gr, t1_raw, t1, diff, g1;
  logic signed [PW-1:0]           g1_rnd;
  logic signed [AW-1:0]           mul_a;
  logic signed [BW-1:0]           mul_b;
  logic signed [PW-1:0]           mul_p;
  logic                           mul_en;

  function automatic logic signed [S-1:0] scale_out(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    r = (p + RoundHalf) >>> 29;
    if (r > SatHi) begin
      r = SatHi;
    end else if (r < SatLo) begin
      r = SatLo;
    end
    return r[S-1:0];
  endfunction

  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;
  assign swap_now_o  = swap_out_q;
  assign fading_o    = fading_out_q;

  always_comb begin
    mode_n   = mode_q;
    swap_n   = 1'b0;
    phase_n  = phase_q;
    phase_sum = {1'b0, phase_q} + {1'b0, fade_in_step_q};
    if (req_q && mode_q != rcsd_pkg::ModeFadeOut) begin
      mode_n = rcsd_pkg::ModeFadeOut;
    end
    if (mode_n == rcsd_pkg::ModeFadeOut && phase_q == '0) begin
      mode_n = rcsd_pkg::ModeFadeIn;
      swap_n = 1'b1;
    end else if (mode_n == rcsd_pkg::ModeFadeIn && phase_q >= rcsd_pkg::PhaseOne) begin
      mode_n = rcsd_pkg::ModeNormal;
    end
    fading_n = (mode_n == rcsd_pkg::ModeFadeOut) || (mode_n == rcsd_pkg::ModeFadeIn);
    if (mode_n == rcsd_pkg::ModeFadeOut) begin
      phase_n = (phase_q > fade_out_step_q) ? phase_q - fade_out_step_q : '0;
    end else if (mode_n == rcsd_pkg::ModeFadeIn) begin
      phase_n = (phase_sum > {1'b0, rcsd_pkg::PhaseOne}) ? rcsd_pkg::PhaseOne
                                                          : phase_sum[rcsd_pkg::PhaseBits-1:0];
    end
  end

  always_comb begin
    gl = rcsd_pkg::GainOne;
    gr = rcsd_pkg::GainOne;
    if (balance_q > 0) begin
      gl = (balance_q >= 17'sd32768) ? '0 : rcsd_pkg::GainOne - balance_q[15:0];
    end
    if (balance_q < 0) begin
      gr = (balance_q <= -17'sd32768) ? '0 : rcsd_pkg::GainOne - 16'(-balance_q);
    end
  end

  assign t1_raw = last_q ? rcsd_pkg::GainOne : rom_q;
  assign t1     = (t1_raw < t0_q) ? t0_q : t1_raw;
  assign diff   = t1 - t0_q;
  assign g1_rnd = prod_q + $signed(PW'(1) << 14);
  assign g1     = g1_rnd[30:15];

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      StInterp: begin
        mul_a = AW'($signed({1'b0, diff}));
        mul_b = BW'($signed({1'b0, phase_q[F-1:0]}));
      end
      StGl: begin
        mul_a = AW'($signed({1'b0, gl}));
        mul_b = BW'($signed({1'b0, sg_q}));
      end
      StGr: begin
        mul_a = AW'($signed({1'b0, gr}));
        mul_b = BW'($signed({1'b0, sg_q}));
      end
      StGgl, StGgr: begin
        mul_a = AW'($signed({1'b0, g1}));
        mul_b = BW'($signed({1'b0, output_gain_q}));
      end
      StXl: begin
        mul_a = AW'(x_l_q);
        mul_b = prod_q[BW-1:0];
      end
      StXr: begin
        mul_a = AW'(x_r_q);
        mul_b = prod_q[BW-1:0];
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    rom_q <= CosRom[rom_addr_q];
    if (mul_en) begin
      prod_q <= mul_p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      mode_q          <= rcsd_pkg::ModeNormal;
      phase_q         <= rcsd_pkg::PhaseOne;
      out_valid_q     <= 1'b0;
      fade_out_step_q <= 17'd228;
      fade_in_step_q  <= 17'd49;
      output_gain_q   <= 16'd16384;
      balance_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          rcsd_pkg::CfgFadeOutStep: fade_out_step_q <= cfg_data_i;
          rcsd_pkg::CfgFadeInStep:  fade_in_step_q  <= cfg_data_i;
          rcsd_pkg::CfgOutputGain:  output_gain_q   <= cfg_data_i[15:0];
          rcsd_pkg::CfgBalance:     balance_q       <= $signed(cfg_data_i);
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i && state_q != StDone) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            x_l_q   <= left_in_i;
            x_r_q   <= right_in_i;
            req_q   <= change_request_i;
            state_q <= StMode;
          end
        end
        StMode: begin
          mode_q     <= mode_n;
          phase_q    <= phase_n;
          swap_q     <= swap_n;
          fading_q   <= fading_n;
          rom_addr_q <= phase_n[15:F];
          last_q     <= (phase_n[15:F] == {TB{1'b1}});
          state_q    <= StRd0;
        end
        StRd0: begin
          rom_addr_q <= rom_addr_q + TB'(1);
          state_q    <= StRd1;
        end
        StRd1: begin
          t0_q    <= rom_q;
          state_q <= StInterp;
        end
        StInterp: begin
          state_q <= StDuck;
        end
        StDuck: begin
          if (!fading_q || phase_q >= rcsd_pkg::PhaseOne) begin
            sg_q <= rcsd_pkg::GainOne;
          end else begin
            sg_q <= t0_q + prod_q[F+15:F];
          end
          state_q <= StGl;
        end
        StGl:  state_q <= StGgl;
        StGgl: state_q <= StXl;
        StXl:  state_q <= StGr;
        StGr: begin
          left_q  <= scale_out(prod_q);
          state_q <= StGgr;
        end
        StGgr: state_q <= StXr;
        StXr:  state_q <= StDone;
        StDone: begin
          if (!out_valid_q || out_ready_i) begin
            left_out_q   <= left_q;
            right_out_q  <= scale_out(prod_q);
            swap_out_q   <= swap_q;
            fading_out_q <= fading_q;
            out_valid_q  <= 1'b1;
            state_q      <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire
